[hdl/iee_pkg.sv]
`default_nettype none

package iee_pkg;

  // ASCII codes of the accepted characters
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // Result status codes
  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StDiv0   = 2'd1,
    StSyntax = 2'd2,
    StOvf    = 2'd3
  } status_e;

  // Pending product operation
  typedef enum logic [1:0] {
    PopNone = 2'd0,
    PopMul  = 2'd1,
    PopDiv  = 2'd2
  } prod_op_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic digit;
    logic syntax;
    logic opnd_int;
    logic opnd_ovf;
    logic div_zero;
    logic mul_start;
    logic mul_step;
    logic mul_end;
    logic div_start;
    logic div_step;
    logic div_end;
    logic set_prod;
    logic set_expect;
    logic term_add;
    logic term_mid;
    logic out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic     err;
    logic     is_digit;
    logic     is_op;
    logic     is_prod;
    logic     need_opnd;
    logic     last;
    logic     opnd_big;
    logic     opnd_zero;
    prod_op_e pop;
    logic     mul_done;
    logic     div_done;
    logic     out_free;
  } stat_t;

endpackage

`default_nettype wire

[hdl/iee_dp.sv]
`default_nettype none

module iee_dp #(
  parameter int VALUE_WIDTH   = 64,
  parameter int FRAC_BITS     = 32,
  parameter int OPERAND_WIDTH = 32
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire  [7:0]              character_i,
  input  wire                     last_i,
  input  iee_pkg::cmd_t           cmd_i,
  output iee_pkg::stat_t          stat_o,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic [VALUE_WIDTH-1:0]  value_o,
  output logic [1:0]              status_o
);
  import iee_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int OW = OPERAND_WIDTH;
  localparam int PW = VW + OW + 1;
  localparam int CW = $clog2(VW + 1);
  localparam int NShift = (VW - 1 - FRAC_BITS > 0) ? (VW - 1 - FRAC_BITS) : 0;

  logic [7:0]    char_q, char_d;
  logic          last_q, last_d;
  logic [OW-1:0] accum_q, accum_d;
  logic [VW-1:0] term_q, term_d;
  logic [VW-1:0] sum_q, sum_d;
  prod_op_e      pop_q, pop_d;
  logic          sign_q, sign_d;
  logic          expect_q, expect_d;
  status_e       err_q, err_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] acc_q, acc_d;
  logic [PW-1:0] mcand_q, mcand_d;
  logic [OW-1:0] mplr_q, mplr_d;
  logic [VW-1:0] dvd_q, dvd_d;
  logic [OW-1:0] rem_q, rem_d;
  logic          neg_q, neg_d;
  logic          ovalid_q, ovalid_d;
  logic [VW-1:0] value_q, value_d;
  status_e       status_q, status_d;

  logic [OW+3:0] a10;
  logic [OW:0]   trial;
  logic [OW:0]   diff;
  logic          ge;
  logic [VW:0]   sx, tx, sres;
  logic          is_plus, is_minus, is_star, is_slash;

  // Decode the held word
  assign is_plus  = (char_q == CharPlus);
  assign is_minus = (char_q == CharMinus);
  assign is_star  = (char_q == CharStar);
  assign is_slash = (char_q == CharSlash);

  // Arithmetic helpers
  assign a10   = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1)
               + (OW+4)'(char_q[3:0]);
  assign trial = {rem_q, dvd_q[VW-1]};
  assign diff  = trial - {1'b0, accum_q};
  assign ge    = (trial >= {1'b0, accum_q});
  assign sx    = {sum_q[VW-1], sum_q};
  assign tx    = {term_q[VW-1], term_q};
  assign sres  = sign_q ? (sx - tx) : (sx + tx);

  // Report status
  always_comb begin
    stat_o.err       = (err_q != StOk);
    stat_o.is_digit  = (char_q >= CharZero) && (char_q <= CharNine);
    stat_o.is_op     = is_plus || is_minus || is_star || is_slash;
    stat_o.is_prod   = is_star || is_slash;
    stat_o.need_opnd = expect_q;
    stat_o.last      = last_q;
    stat_o.opnd_big  = ((accum_q >> NShift) != '0);
    stat_o.opnd_zero = (accum_q == '0);
    stat_o.pop       = pop_q;
    stat_o.mul_done  = (cnt_q == CW'(OW));
    stat_o.div_done  = (cnt_q == CW'(VW));
    stat_o.out_free  = !ovalid_q || !out_stall_i;
  end

  // Next state of the datapath
  always_comb begin
    char_d   = char_q;
    last_d   = last_q;
    accum_d  = accum_q;
    term_d   = term_q;
    sum_d    = sum_q;
    pop_d    = pop_q;
    sign_d   = sign_q;
    expect_d = expect_q;
    err_d    = err_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplr_d   = mplr_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    ovalid_d = ovalid_q && out_stall_i;
    value_d  = value_q;
    status_d = status_q;

    if (cmd_i.load) begin
      char_d = character_i;
      last_d = last_i;
    end
    // Accumulate one decimal digit
    if (cmd_i.digit) begin
      if (a10[OW+3:OW] != 4'b0) begin
        err_d = StOvf;
      end else begin
        accum_d = a10[OW-1:0];
      end
      expect_d = 1'b0;
    end
    if (cmd_i.syntax)   err_d = StSyntax;
    if (cmd_i.opnd_ovf) err_d = StOvf;
    if (cmd_i.div_zero) err_d = StDiv0;
    // Operand starts a fresh term
    if (cmd_i.opnd_int) begin
      term_d  = VW'(accum_q) << FRAC_BITS;
      accum_d = '0;
    end
    // Shift-add multiply, one multiplier bit a cycle
    if (cmd_i.mul_start) begin
      acc_d   = '0;
      mcand_d = {{(PW-VW){term_q[VW-1]}}, term_q};
      mplr_d  = accum_q;
      cnt_d   = '0;
    end
    if (cmd_i.mul_step) begin
      if (mplr_q[0]) acc_d = acc_q + mcand_q;
      mcand_d = mcand_q << 1;
      mplr_d  = mplr_q >> 1;
      cnt_d   = cnt_q + CW'(1);
    end
    if (cmd_i.mul_end) begin
      if ((&acc_q[PW-1:VW-1]) || !(|acc_q[PW-1:VW-1])) begin
        term_d  = acc_q[VW-1:0];
        accum_d = '0;
      end else begin
        err_d = StOvf;
      end
    end
    // Restoring divide on magnitudes, one quotient bit a cycle
    if (cmd_i.div_start) begin
      neg_d = term_q[VW-1];
      dvd_d = term_q[VW-1] ? (-term_q) : term_q;
      rem_d = '0;
      cnt_d = '0;
    end
    if (cmd_i.div_step) begin
      rem_d = ge ? diff[OW-1:0] : trial[OW-1:0];
      dvd_d = {dvd_q[VW-2:0], ge};
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.div_end) begin
      term_d  = neg_q ? (-dvd_q) : dvd_q;
      accum_d = '0;
    end
    if (cmd_i.set_prod)   pop_d = is_star ? PopMul : PopDiv;
    if (cmd_i.set_expect) expect_d = 1'b1;
    // Fold the term into the sum
    if (cmd_i.term_add) begin
      if (sres[VW] != sres[VW-1]) begin
        err_d = StOvf;
      end else begin
        sum_d  = sres[VW-1:0];
        term_d = '0;
      end
    end
    if (cmd_i.term_mid) begin
      pop_d    = PopNone;
      sign_d   = is_minus;
      expect_d = 1'b1;
    end
    // Hand over the result and drop the expression state
    if (cmd_i.out_load) begin
      ovalid_d = 1'b1;
      value_d  = (err_q == StOk) ? sum_q : '0;
      status_d = err_q;
      accum_d  = '0;
      term_d   = '0;
      sum_d    = '0;
      pop_d    = PopNone;
      sign_d   = 1'b0;
      expect_d = 1'b1;
      err_d    = StOk;
    end
  end

  // Control and expression state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q  <= '0;
      term_q   <= '0;
      sum_q    <= '0;
      pop_q    <= PopNone;
      sign_q   <= 1'b0;
      expect_q <= 1'b1;
      err_q    <= StOk;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      accum_q  <= accum_d;
      term_q   <= term_d;
      sum_q    <= sum_d;
      pop_q    <= pop_d;
      sign_q   <= sign_d;
      expect_q <= expect_d;
      err_q    <= err_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    last_q   <= last_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplr_q   <= mplr_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign out_valid_o = ovalid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

[hdl/iee_ctrl.sv]
`default_nettype none

module iee_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  iee_pkg::stat_t  stat_i,
  output iee_pkg::cmd_t   cmd_o
);
  import iee_pkg::*;

  typedef enum logic [8:0] {
    SIdle   = 9'b000000001,
    SDecode = 9'b000000010,
    SOpnd   = 9'b000000100,
    SMul    = 9'b000001000,
    SDiv    = 9'b000010000,
    SPost   = 9'b000100000,
    STerm   = 9'b001000000,
    SEnd    = 9'b010000000,
    SLoad   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;

  // Sequence one word through the datapath
  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          fin_d      = 1'b0;
          state_d    = SDecode;
        end
      end
      SDecode: begin
        state_d = SEnd;
        if (!stat_i.err) begin
          if (stat_i.is_digit) begin
            cmd_o.digit = 1'b1;
          end else if (stat_i.is_op) begin
            if (stat_i.need_opnd) cmd_o.syntax = 1'b1;
            else state_d = SOpnd;
          end else begin
            cmd_o.syntax = 1'b1;
          end
        end
      end
      SOpnd: begin
        state_d = SPost;
        if (stat_i.opnd_big) begin
          cmd_o.opnd_ovf = 1'b1;
        end else begin
          case (stat_i.pop)
            PopMul: begin
              cmd_o.mul_start = 1'b1;
              state_d         = SMul;
            end
            PopDiv: begin
              if (stat_i.opnd_zero) begin
                cmd_o.div_zero = 1'b1;
              end else begin
                cmd_o.div_start = 1'b1;
                state_d         = SDiv;
              end
            end
            default: cmd_o.opnd_int = 1'b1;
          endcase
        end
      end
      SMul: begin
        if (stat_i.mul_done) begin
          cmd_o.mul_end = 1'b1;
          state_d       = SPost;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      SDiv: begin
        if (stat_i.div_done) begin
          cmd_o.div_end = 1'b1;
          state_d       = SPost;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      SPost: begin
        if (fin_q) begin
          state_d = stat_i.err ? SLoad : STerm;
        end else if (stat_i.err) begin
          cmd_o.set_expect = 1'b1;
          state_d          = SEnd;
        end else if (stat_i.is_prod) begin
          cmd_o.set_prod   = 1'b1;
          cmd_o.set_expect = 1'b1;
          state_d          = SEnd;
        end else begin
          state_d = STerm;
        end
      end
      STerm: begin
        cmd_o.term_add = 1'b1;
        cmd_o.term_mid = !fin_q;
        state_d        = fin_q ? SLoad : SEnd;
      end
      SEnd: begin
        if (!stat_i.last) begin
          state_d = SIdle;
        end else if (stat_i.err) begin
          state_d = SLoad;
        end else if (stat_i.need_opnd) begin
          cmd_o.syntax = 1'b1;
          state_d      = SLoad;
        end else begin
          fin_d   = 1'b1;
          state_d = SOpnd;
        end
      end
      SLoad: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  assign in_stall_o = (state_q != SIdle);

endmodule

`default_nettype wire

[hdl/infix_expression_evaluator.sv]
// Channel  Handshake                 Word
// in       in_valid_i / in_stall_o   character_i, last_i
// out      out_valid_o / out_stall_i value_o, status_o
//
// A digit or a bad character is only decoded; an operator closing an
// operand also folds that operand into the term, through a multiply
// (shift-add unit) or a divide (restoring divider) where one is pending.
// The last word adds the closing of its operand and term and the load of the result.
// Reset clears the expression state and empties the output register.
// A stalled result holds in the output register; the next expression is
// taken meanwhile, and only its own result waits for the register.
`default_nettype none

module infix_expression_evaluator #(
  parameter int VALUE_WIDTH   = 64,
  parameter int FRAC_BITS     = 32,
  parameter int OPERAND_WIDTH = 32
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire  [7:0]              character_i,
  input  wire                     last_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic [VALUE_WIDTH-1:0]  value_o,
  output logic [1:0]              status_o
);
  import iee_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  iee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  iee_dp #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRAC_BITS     (FRAC_BITS),
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .character_i (character_i),
    .last_i      (last_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  // A failed expression carries a zero value
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != StOk)) |-> (value_o == '0))
    else $error("nonzero value with error status");

  // Each word passes through decode before the next is taken
  a_one_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second word taken straight after the first");

  // Hold a stalled result word
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(value_o) && $stable(status_o)))
    else $error("stalled result word changed or dropped");

endmodule

`default_nettype wire

[verif/tb_infix_expression_evaluator.sv]
`default_nettype none

module tb_infix_expression_evaluator;
  timeunit 1ns;
  timeprecision 1ps;
  import iee_pkg::*;

  localparam int VW = 64;
  localparam int FB = 32;
  localparam int OW = 32;
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam longint unsigned OPMAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - OW);
  localparam longint unsigned INTMAX = 64'(VMAX) >> FB;
  localparam int LIMIT = 4000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] character_i = 8'h30;
  logic last_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [VW-1:0] value_o;
  logic [1:0] status_o;

  infix_expression_evaluator u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .character_i, .last_i,
    .out_valid_o, .out_stall_i, .value_o, .status_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state of the evaluator
  longint unsigned digits_acc;
  logic signed [VW-1:0] term_acc, sum_acc;
  prod_op_e prod_op;
  logic neg_sign, want_opnd;
  status_e err;

  typedef struct {logic [VW-1:0] value; status_e status;} answer_t;
  answer_t answers_q[$];
  int errors = 0;
  bit stim_done = 0;
  int cycles = 0;

  function automatic void clear_expr();
    digits_acc = 0; term_acc = 0; sum_acc = 0; prod_op = PopNone;
    neg_sign = 0; want_opnd = 1; err = StOk;
  endfunction

  function automatic void flag(status_e s);
    if (err == StOk) err = s;
  endfunction

  // Fold the finished operand into the term
  function automatic void fold_operand();
    logic signed [VW-1:0] n;
    logic signed [VW+63:0] wide;
    if (digits_acc > INTMAX) begin
      flag(StOvf);
      return;
    end
    n = VW'(digits_acc);
    if (prod_op == PopMul) begin
      wide = (VW+64)'(term_acc) * (VW+64)'(n);
      if (wide > (VW+64)'(VMAX) || wide < (VW+64)'(VMIN)) begin
        flag(StOvf);
        return;
      end
      term_acc = wide[VW-1:0];
    end else if (prod_op == PopDiv) begin
      if (n == 0) begin
        flag(StDiv0);
        return;
      end
      term_acc = term_acc / n;
    end else begin
      term_acc = n <<< FB;
    end
    digits_acc = 0;
  endfunction

  // Add the signed term into the sum
  function automatic void fold_term();
    logic signed [VW:0] r;
    r = neg_sign ? (VW+1)'(sum_acc) - (VW+1)'(term_acc)
                 : (VW+1)'(sum_acc) + (VW+1)'(term_acc);
    if (r > (VW+1)'(VMAX) || r < (VW+1)'(VMIN)) begin
      flag(StOvf);
      return;
    end
    sum_acc = r[VW-1:0];
    term_acc = 0;
  endfunction

  function automatic void eval_char(logic [7:0] ch, logic lst);
    longint unsigned a;
    answer_t ans;
    if (err == StOk) begin
      if (ch >= CharZero && ch <= CharNine) begin
        a = digits_acc * 10 + (ch - CharZero);
        if (a > OPMAX) flag(StOvf);
        else digits_acc = a;
        want_opnd = 0;
      end else if (ch == CharPlus || ch == CharMinus || ch == CharStar ||
                   ch == CharSlash) begin
        if (want_opnd) flag(StSyntax);
        else begin
          fold_operand();
          if (err == StOk) begin
            if (ch == CharStar) prod_op = PopMul;
            else if (ch == CharSlash) prod_op = PopDiv;
            else begin
              fold_term();
              prod_op = PopNone;
              neg_sign = (ch == CharMinus);
            end
          end
          want_opnd = 1;
        end
      end else flag(StSyntax);
    end
    if (!lst) return;
    if (err == StOk) begin
      if (want_opnd) flag(StSyntax);
      else begin
        fold_operand();
        if (err == StOk) fold_term();
      end
    end
    ans.value = (err == StOk) ? sum_acc : '0;
    ans.status = err;
    answers_q.insert(answers_q.size(), ans);
    clear_expr();
  endfunction

  // Directed table; fixed answers where obvious, otherwise predictor only
  typedef struct {string txt; bit fixed; logic [VW-1:0] value; status_e status;} row_t;
  row_t rows[] = '{
    '{"7", 1, 64'sd7 <<< FB, StOk},
    '{"1+2*3", 1, 64'sd7 <<< FB, StOk},
    '{"9-4-3", 1, 64'sd2 <<< FB, StOk},
    '{"7/2", 1, 64'h3_8000_0000, StOk},
    '{"5/0", 1, '0, StDiv0},
    '{"+3", 1, '0, StSyntax},
    '{"3+", 1, '0, StSyntax},
    '{"3**2", 1, '0, StSyntax},
    '{"3a2", 1, '0, StSyntax},
    '{"4294967296", 1, '0, StOvf},
    '{"2147483648", 1, '0, StOvf},
    '{"2147483647", 1, 64'h7FFF_FFFF_0000_0000, StOk},
    '{"0-2147483647-1", 1, 64'h8000_0000_0000_0000, StOk},
    '{"2147483647+1", 1, '0, StOvf},
    '{"65536*65536", 1, '0, StOvf},
    '{"0", 1, '0, StOk},
    '{"1/3*3", 0, '0, StOk},
    '{"100/7/3-2*5+8", 0, '0, StOk},
    '{"/0x+\377", 1, '0, StSyntax},
    '{"9/0/0+x", 1, '0, StDiv0},
    '{"0*5-1/2", 0, '0, StOk}
  };

  task automatic send(logic [7:0] ch, logic lst);
    character_i <= ch;
    last_i <= lst;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    eval_char(ch, lst);
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_char(int mode);
    logic [7:0] ops[4] = '{CharPlus, CharMinus, CharStar, CharSlash};
    if (mode == 0) return 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1)) return 8'(CharZero + $urandom_range(0, 9));
    return ops[$urandom_range(0, 3)];
  endfunction

  // Drive the directed words, then random expressions
  initial begin
    int sent, burst, n, terms, dl, len;
    logic [7:0] ops[4] = '{CharPlus, CharMinus, CharStar, CharSlash};
    answer_t fix;
    clear_expr();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    burst = $urandom_range(1, 12);
    foreach (rows[i]) begin
      for (int k = 0; k < rows[i].txt.len(); k++) begin
        send(rows[i].txt[k], k == rows[i].txt.len() - 1);
        if (k == rows[i].txt.len() - 1 && rows[i].fixed) begin
          fix = answers_q[$];
          if (fix.value !== rows[i].value || fix.status !== rows[i].status)
            $display("%0t row %0d: table %h/%0d, predictor %h/%0d", $time, i,
                     rows[i].value, rows[i].status, fix.value, fix.status);
          answers_q[$].value = rows[i].value;
          answers_q[$].status = rows[i].status;
        end
        if (--burst == 0) begin
          idle_gap();
          burst = $urandom_range(1, 12);
        end
      end
    end
    sent = 0;
    while (sent < 1250) begin
      n = $urandom_range(0, 9);
      if (n < 7) begin
        // well formed: operands of 1 to 3 digits, now and then 8 to 11, random operators
        terms = $urandom_range(1, 5);
        for (int t = 0; t < terms; t++) begin
          dl = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 11)
                                            : $urandom_range(1, 3);
          for (int d = 0; d < dl; d++) begin
            send(8'(CharZero + $urandom_range(0, 9)), t == terms - 1 && d == dl - 1);
            sent++;
          end
          if (t != terms - 1) begin
            send(ops[$urandom_range(0, 3)], 1'b0);
            sent++;
          end
          if ($urandom_range(0, 3) == 0) idle_gap();
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          send(rand_char(n == 9 ? 0 : 1), k == len - 1);
          sent++;
        end
      end
      if ($urandom_range(0, 2) == 0) idle_gap();
    end
    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  // Stall the result side on its own pattern
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 20) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(20, 200)) @(negedge clk_i);
      end else begin
        case ($urandom_range(0, 3))
          0: out_stall_i <= ($urandom_range(0, 1) == 1);
          1: out_stall_i <= 1'b1;
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // Compare each accepted result word
  always @(posedge clk_i) begin
    answer_t ans;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answers_q.size() == 0) begin
        $display("%0t unexpected result %h/%0d", $time, value_o, status_o);
        errors++;
      end else begin
        ans = answers_q.pop_front();
        if (value_o !== ans.value) begin
          $display("%0t value exp %h got %h", $time, ans.value, value_o);
          errors++;
        end
        if (status_o !== ans.status) begin
          $display("%0t status exp %0d got %0d", $time, ans.status, status_o);
          errors++;
        end
      end
    end
  end

  // Finish after drain, or on timeout
  initial begin
    @(posedge rst_ni);
    while (!(stim_done && answers_q.size() == 0) && cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
    end else begin
      repeat (200) @(posedge clk_i);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/iee_pkg.sv
hdl/iee_dp.sv
hdl/iee_ctrl.sv
hdl/infix_expression_evaluator.sv
verif/tb_infix_expression_evaluator.sv
